@@ design/bkv_pkg.sv @@
// ----------------------------------------------------------------------------
// bkv_pkg
// Shared constants and controller/datapath interface types for the brace
// key/value deframer.
// ----------------------------------------------------------------------------
package bkv_pkg;

    // Store geometry
    localparam int STORE_DEPTH      = 32;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int CNT_W            = ADDR_W + 1;
    localparam int MAX_TEXT_LEN_DEF = 32;

    // Framing characters
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Result kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Parse phases
    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_KEY   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // clear both counts
        logic key_wr;    // store byte into key store
        logic val_wr;    // store byte into value store
        logic idx_clr;   // rewind emit index
        logic load_out;  // read stores and load the output register
        logic idx_inc;   // advance emit index
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic key_full;
        logic val_full;
        logic out_last;
    } status_t;

endpackage

@@ design/bkv_datapath.sv @@
// ----------------------------------------------------------------------------
// bkv_datapath
// Key and value byte stores with fill counts, the emit index and the
// registered result word.
// ----------------------------------------------------------------------------
module bkv_datapath #(
    parameter int MAX_TEXT_LEN = bkv_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bkv_pkg::cmd_t   cmd,
    input  logic [7:0]      rx_byte,
    output bkv_pkg::status_t status,
    output logic [1:0]      item_kind,
    output logic [7:0]      out_byte,
    output logic            last_of_message
);
    import bkv_pkg::*;

    logic [7:0]       key_mem [STORE_DEPTH];
    logic [7:0]       val_mem [STORE_DEPTH];

    logic [CNT_W-1:0] key_count_reg;
    logic [CNT_W-1:0] key_count_next;
    logic [CNT_W-1:0] value_count_reg;
    logic [CNT_W-1:0] value_count_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;

    logic [1:0]       kind_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    logic [CNT_W:0]   total;
    logic             in_key;
    logic [CNT_W-1:0] val_idx;
    logic             is_empty;
    logic             is_last;

    // Emit bookkeeping
    assign total    = {1'b0, key_count_reg} + {1'b0, value_count_reg};
    assign in_key   = idx_reg < key_count_reg;
    assign val_idx  = idx_reg - key_count_reg;
    assign is_empty = total == '0;
    assign is_last  = ({1'b0, idx_reg} + (CNT_W+1)'(1)) == total;

    assign status.key_full = key_count_reg >= CNT_W'(MAX_TEXT_LEN);
    assign status.val_full = value_count_reg >= CNT_W'(MAX_TEXT_LEN);
    assign status.out_last = last_reg;

    // Next values for counts and index
    always_comb
    begin
        key_count_next   = key_count_reg;
        value_count_next = value_count_reg;
        idx_next         = idx_reg;
        if (cmd.start)
        begin
            key_count_next   = '0;
            value_count_next = '0;
        end
        if (cmd.key_wr)
        begin
            key_count_next = key_count_reg + CNT_W'(1);
        end
        if (cmd.val_wr)
        begin
            value_count_next = value_count_reg + CNT_W'(1);
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg   <= '0;
            value_count_reg <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            key_count_reg   <= key_count_next;
            value_count_reg <= value_count_next;
            idx_reg         <= idx_next;
        end
    end

    // Store writes and registered read into the result word
    always_ff @(posedge clk)
    begin
        if (cmd.key_wr)
        begin
            key_mem[key_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.val_wr)
        begin
            val_mem[value_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.load_out)
        begin
            if (is_empty)
            begin
                kind_reg <= KIND_EMPTY;
                byte_reg <= '0;
                last_reg <= 1'b1;
            end
            else if (in_key)
            begin
                kind_reg <= KIND_KEY;
                byte_reg <= key_mem[idx_reg[ADDR_W-1:0]];
                last_reg <= is_last;
            end
            else
            begin
                kind_reg <= KIND_VALUE;
                byte_reg <= val_mem[val_idx[ADDR_W-1:0]];
                last_reg <= is_last;
            end
        end
    end

    assign item_kind       = kind_reg;
    assign out_byte        = byte_reg;
    assign last_of_message = last_reg;

endmodule

@@ design/bkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// bkv_ctrl
// Parse phase tracking and the emit sequencer; issues commands to the
// datapath and drives both handshakes.
// ----------------------------------------------------------------------------
module bkv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_ready,
    input  bkv_pkg::status_t status,
    output bkv_pkg::cmd_t    cmd
);
    import bkv_pkg::*;

    typedef enum logic [2:0] {
        ST_PARSE = 3'b001,
        ST_READ  = 3'b010,
        ST_SEND  = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_ready  = state_reg == ST_PARSE;
    assign out_valid = state_reg == ST_SEND;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    // Decode the received byte and sequence the emit run
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        case (state_reg)
            ST_PARSE:
            begin
                if (in_xfer)
                begin
                    if (rx_byte == CH_OPEN)
                    begin
                        cmd.start  = 1'b1;
                        phase_next = PH_KEY;
                    end
                    else if (rx_byte == CH_CLOSE && phase_reg != PH_VALUE)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_WAIT:
                            begin
                                phase_next = PH_WAIT;
                            end
                            PH_KEY:
                            begin
                                if (rx_byte == CH_COLON)
                                begin
                                    phase_next = PH_VALUE;
                                end
                                else if (!status.key_full)
                                begin
                                    cmd.key_wr = 1'b1;
                                end
                            end
                            PH_VALUE:
                            begin
                                if (rx_byte == CH_CLOSE)
                                begin
                                    phase_next  = PH_WAIT;
                                    cmd.idx_clr = 1'b1;
                                    state_next  = ST_READ;
                                end
                                else if (!status.val_full)
                                begin
                                    cmd.val_wr = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_WAIT;
                            end
                        endcase
                    end
                end
            end
            ST_READ:
            begin
                cmd.load_out = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_xfer)
                begin
                    if (status.out_last)
                    begin
                        state_next = ST_PARSE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PARSE;
            phase_reg <= PH_WAIT;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

@@ design/brace_key_value_deframer_core.sv @@
// ----------------------------------------------------------------------------
// brace_key_value_deframer_core
// Latency: a received byte is parsed and stored in the cycle it transfers.
// Throughput: one byte per cycle while parsing; a completed message emits
// its results one at a time, each by a store read and then an output transfer,
// during which no input is taken.
// Reset (rst_n, async, active low): parser waits for '{', counts cleared.
// ----------------------------------------------------------------------------
module brace_key_value_deframer_core #(
    parameter int MAX_TEXT_LEN = bkv_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] item_kind
    output logic       m_axis_tlast    // last_of_message
);
    import bkv_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Parser and emit sequencer
    bkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .rx_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Byte stores and result register
    bkv_datapath #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rx_byte         (s_axis_tdata),
        .status          (status),
        .item_kind       (m_axis_tuser),
        .out_byte        (m_axis_tdata),
        .last_of_message (m_axis_tlast)
    );

endmodule

@@ test/brace_key_value_deframer_core_chk.sv @@
// ----------------------------------------------------------------------------
// brace_key_value_deframer_core_chk
// Scoreboard for the brace key/value deframer. Watches both stream channels,
// mirrors the brace parser and its key and value stores to build the
// expected result run of each completed message, and compares every output
// transfer field by field in order.
// ----------------------------------------------------------------------------
module brace_key_value_deframer_core_chk #(
    parameter int MAX_TEXT_LEN = bkv_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic [1:0] m_axis_tuser,   // [1:0] item_kind
    input  logic       m_axis_tlast,   // last_of_message
    output int         fail_count,
    output int         pending,
    output int         results_seen,
    output int         messages_seen
);
    import bkv_pkg::*;

    localparam int TEXT_CAP = (MAX_TEXT_LEN < STORE_DEPTH) ? MAX_TEXT_LEN : STORE_DEPTH;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] out_byte;
        logic       last_flag;
    } deframed_t;

    // Mirror of the parser state
    logic [1:0]       phase;
    logic [7:0]       key_mem   [STORE_DEPTH];
    logic [7:0]       value_mem [STORE_DEPTH];
    logic [CNT_W-1:0] key_len;
    logic [CNT_W-1:0] value_len;

    deframed_t deframed_q [$];
    deframed_t want;

    // Append one expected result at the tail of the queue
    task automatic add_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic last_flag);
        deframed_t r;
        r.item_kind = kind;
        r.out_byte  = data;
        r.last_flag = last_flag;
        deframed_q  = {deframed_q, r};
    endtask

    // Advance the parser mirror by one received byte; queue the emitted run
    task automatic parse_byte(input logic [7:0] c);
        int total;
        int n;
        n = 0;
        if (c == CH_OPEN)
        begin
            // an open brace always starts a fresh message
            phase     = PH_KEY;
            key_len   = '0;
            value_len = '0;
        end
        else if (c == CH_CLOSE && phase != PH_VALUE)
        begin
            phase = PH_WAIT;
        end
        else
        begin
            case (phase)
                PH_WAIT: ;
                PH_KEY:
                begin
                    if (c == CH_COLON)
                    begin
                        phase = PH_VALUE;
                    end
                    else if (key_len < TEXT_CAP)
                    begin
                        key_mem[key_len[ADDR_W-1:0]] = c;
                        key_len++;
                    end
                end
                PH_VALUE:
                begin
                    if (c == CH_CLOSE)
                    begin
                        phase = PH_WAIT;
                        total = int'(key_len) + int'(value_len);
                        if (total == 0)
                            add_result(KIND_EMPTY, 8'h00, 1'b1);
                        for (int i = 0; i < int'(key_len); i++)
                        begin
                            add_result(KIND_KEY, key_mem[i], (n + 1 == total));
                            n++;
                        end
                        for (int i = 0; i < int'(value_len); i++)
                        begin
                            add_result(KIND_VALUE, value_mem[i], (n + 1 == total));
                            n++;
                        end
                    end
                    else if (value_len < TEXT_CAP)
                    begin
                        value_mem[value_len[ADDR_W-1:0]] = c;
                        value_len++;
                    end
                end
                default: phase = PH_WAIT;
            endcase
        end
    endtask

    // Compare output transfers first, then fold in the input transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase     = PH_WAIT;
            key_len   = '0;
            value_len = '0;
            deframed_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tlast)
                    messages_seen++;
                if (deframed_q.size() == 0)
                begin
                    $error("unexpected result: item_kind %0d, out_byte 0x%02h, last %0b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (m_axis_tuser !== want.item_kind)
                    begin
                        $error("item_kind mismatch: expected %0d, got %0d",
                               want.item_kind, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected 0x%02h, got 0x%02h",
                               want.out_byte, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last_flag)
                    begin
                        $error("last_of_message mismatch: expected %0b, got %0b",
                               want.last_flag, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata);
        end
        pending = deframed_q.size();
    end

endmodule

@@ test/brace_key_value_deframer_core_tb.sv @@
// ----------------------------------------------------------------------------
// brace_key_value_deframer_core_tb
// Stimulus and verdict for the brace key/value deframer. Sends a short
// directed set of frames (ignored bytes, aborts, restarts, empty fields,
// colons in the value), then random frames with random content, overlong
// fields, noise and broken frames, under random idle bursts on both sides.
// ----------------------------------------------------------------------------
module brace_key_value_deframer_core_tb;
    import bkv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [1:0] m_axis_tuser;           // [1:0] item_kind
    logic       m_axis_tlast;           // last_of_message

    int fail_count;
    int pending;
    int results_seen;
    int messages_seen;

    bit         calm = 1'b0;
    int         bytes_sent = 0;
    int         framed_bytes = 0;
    int         cycles = 0;
    int         stall_left = 0;
    logic [7:0] directed_bytes [28];

    brace_key_value_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    brace_key_value_deframer_core_chk chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .messages_seen (messages_seen)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive output ready with random stall bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Send one byte, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Drop valid and hold off until every queued result has been transferred
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Random text byte: never a brace, a colon only inside a value
    function automatic logic [7:0] text_byte(input bit in_value);
        logic [7:0] c;
        if (in_value && $urandom_range(0, 7) == 0)
            return CH_COLON;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_OPEN || c == CH_CLOSE || c == CH_COLON);
        return c;
    endfunction

    // Field length: short, or past the store cap when asked
    function automatic int field_len(input bit force_long);
        if (force_long)
            return $urandom_range(33, 38);
        return $urandom_range(0, 6);
    endfunction

    task automatic send_text(input int n, input bit in_value);
        repeat (n)
        begin
            send_byte(text_byte(in_value));
            framed_bytes++;
        end
    endtask

    task automatic send_mark(input logic [7:0] c);
        send_byte(c);
        framed_bytes++;
    endtask

    // Stimulus
    initial
    begin
        int frame_no;
        int shape;
        int kl;
        int vl;

        directed_bytes = '{
            8'h00, 8'hFF, CH_CLOSE,                                      // ignored while waiting
            CH_OPEN, CH_CLOSE,                                           // close brace in key aborts
            CH_OPEN, 8'h61, CH_OPEN, 8'h62, CH_COLON, 8'h63, CH_CLOSE,   // restart in key
            CH_OPEN, CH_COLON, 8'hFF, CH_CLOSE,                          // empty key
            CH_OPEN, 8'h00, CH_COLON, CH_COLON, CH_CLOSE,                // colon kept in value
            CH_OPEN, 8'h6B, CH_COLON, 8'h61, CH_OPEN, CH_COLON, CH_CLOSE // restart in value, empty
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        wait_drained();

        // Random frames: first two well-formed, the second with both fields past the cap
        frame_no = 0;
        while (bytes_sent < 115 || frame_no < 4)
        begin
            if (bytes_sent >= 95)
                calm = 1'b1;
            shape = (frame_no < 2) ? 0 : $urandom_range(0, 9);
            kl = field_len(frame_no == 1);
            vl = field_len(frame_no == 1);
            if (shape <= 6)
            begin
                send_mark(CH_OPEN);
                send_text(kl, 1'b0);
                send_mark(CH_COLON);
                send_text(vl, 1'b1);
                send_mark(CH_CLOSE);
                frame_no++;
            end
            else if (shape == 7)
            begin
                // noise: any byte, braces included
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (shape == 8)
            begin
                // truncated inside the value; the next open brace restarts
                send_mark(CH_OPEN);
                send_text(kl, 1'b0);
                send_mark(CH_COLON);
                send_text(vl, 1'b1);
            end
            else
            begin
                // close brace in the key drops the frame
                send_mark(CH_OPEN);
                send_text(kl, 1'b0);
                send_mark(CH_CLOSE);
            end
            if (!calm && $urandom_range(0, 9) == 0)
                wait_drained();
        end
        calm = 1'b1;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes (%0d in random frames); checked %0d results in %0d messages.",
                 bytes_sent, framed_bytes, results_seen, messages_seen);
        $display("Covered aborts, restarts, empty and overlong fields, noise and stall bursts.");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
